FILE: rtl/avc_pkg.sv
// ---------------------------------------------------------------------------
// avc_pkg: shared types and constants for the visible-column clipper
// Byte codes, field widths and the burst record that moves a request's
// results from the decode stage to the result buffer.
// ---------------------------------------------------------------------------
package avc_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_W        = 12;
    localparam int COL_BITS_DEF = 12;
    localparam int MAX_RES      = 5;
    localparam int RES_CNT_W    = 3;

    localparam logic [CFG_W-1:0] COLUMN_LIMIT_RST = CFG_W'(79);

    localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1b;
    localparam logic [BYTE_W-1:0] CH_BRACKET = 8'h5b;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h6d;
    localparam logic [BYTE_W-1:0] CSI_FINAL_LO = 8'h40;
    localparam logic [BYTE_W-1:0] CSI_FINAL_HI = 8'h7e;
    localparam logic [1:0]        UTF8_CONT_TAG = 2'b10;

    // results of one request, slot 0 leaves first
    typedef struct packed {
        logic [RES_CNT_W-1:0]           cnt;
        logic [MAX_RES-1:0][BYTE_W-1:0] data;
        logic [MAX_RES-1:0]             ends;
    } t_burst;

endpackage

FILE: rtl/avc_if.sv
// ---------------------------------------------------------------------------
// avc_in_if / avc_out_if: valid/ready channels of the clipper
// Input carries raw string bytes, output carries clipped string bytes.
// ---------------------------------------------------------------------------
interface avc_in_if;
    import avc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface avc_out_if;
    import avc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

FILE: rtl/avc_core.sv
// ---------------------------------------------------------------------------
// avc_core: input register, parse state and result decode
// Holds one request, decides its 0 to 5 result bytes in a single pass and
// hands them to the result buffer when the buffer frees up.
// ---------------------------------------------------------------------------
module avc_core #(
    parameter int COL_BITS = avc_pkg::COL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [avc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [avc_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_is_last,
    input  logic                       i_buf_free,
    output logic                       o_load,
    output avc_pkg::t_burst            o_burst
);
    import avc_pkg::*;

    localparam int CMP_W = (COL_BITS > CFG_W) ? COL_BITS : CFG_W;
    localparam logic [COL_BITS-1:0] COUNT_MAX = {COL_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_HELD   = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_DROP   = 2'd3
    } t_mode;

    logic [CFG_W-1:0]    r_column_limit;
    t_mode               r_mode, n_mode;
    logic [COL_BITS-1:0] r_count, n_count;
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_last;

    logic                consume;
    logic                go_normal;
    logic [RES_CNT_W-1:0] k;
    t_burst              burst;

    function automatic logic at_limit(input logic [COL_BITS-1:0] c,
                                      input logic [CFG_W-1:0] lim);
        return (CMP_W'(c) >= CMP_W'(lim)) || (c == COUNT_MAX);
    endfunction

    assign consume = r_in_valid && i_buf_free;
    assign o_ready = !r_in_valid || consume;
    assign o_load  = consume && (burst.cnt != '0);
    assign o_burst = burst;

    always_comb begin
        burst     = '0;
        k         = '0;
        n_mode    = r_mode;
        n_count   = r_count;
        go_normal = 1'b0;

        case (r_mode)
            MODE_DROP: begin
            end
            MODE_CSI: begin
                burst.data[k] = r_in_byte;
                burst.ends[k] = r_in_last;
                k = k + 1'b1;
                if (r_in_byte >= CSI_FINAL_LO && r_in_byte <= CSI_FINAL_HI) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_HELD: begin
                if (r_in_byte == CH_BRACKET) begin
                    burst.data[0] = CH_ESC;
                    burst.ends[0] = 1'b0;
                    burst.data[1] = CH_BRACKET;
                    burst.ends[1] = r_in_last;
                    k = RES_CNT_W'(2);
                    n_mode = MODE_CSI;
                end else if (at_limit(n_count, r_column_limit)) begin
                    // held ESC is a character that does not fit
                    burst.data[0] = CH_ESC;
                    burst.data[1] = CH_BRACKET;
                    burst.data[2] = CH_ZERO;
                    burst.data[3] = CH_M;
                    burst.ends[3] = 1'b1;
                    k = RES_CNT_W'(4);
                    n_mode = MODE_DROP;
                end else begin
                    n_count = n_count + COL_BITS'(1);
                    burst.data[0] = CH_ESC;
                    burst.ends[0] = 1'b0;
                    k = RES_CNT_W'(1);
                    n_mode = MODE_NORMAL;
                    go_normal = 1'b1;
                end
            end
            default: begin
                go_normal = 1'b1;
            end
        endcase

        if (go_normal) begin
            if (r_in_byte == CH_ESC && !r_in_last) begin
                n_mode = MODE_HELD;
            end else if (r_in_byte[7:6] != UTF8_CONT_TAG) begin
                if (at_limit(n_count, r_column_limit)) begin
                    burst.data[k] = CH_ESC;
                    burst.ends[k] = 1'b0;
                    k = k + 1'b1;
                    burst.data[k] = CH_BRACKET;
                    burst.ends[k] = 1'b0;
                    k = k + 1'b1;
                    burst.data[k] = CH_ZERO;
                    burst.ends[k] = 1'b0;
                    k = k + 1'b1;
                    burst.data[k] = CH_M;
                    burst.ends[k] = 1'b1;
                    k = k + 1'b1;
                    n_mode = MODE_DROP;
                end else begin
                    n_count = n_count + COL_BITS'(1);
                    burst.data[k] = r_in_byte;
                    burst.ends[k] = r_in_last;
                    k = k + 1'b1;
                end
            end else begin
                burst.data[k] = r_in_byte;
                burst.ends[k] = r_in_last;
                k = k + 1'b1;
            end
        end

        // every string starts clean
        if (r_in_last) begin
            n_mode  = MODE_NORMAL;
            n_count = '0;
        end
        burst.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_limit <= COLUMN_LIMIT_RST;
            r_mode         <= MODE_NORMAL;
            r_count        <= '0;
            r_in_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_column_limit <= i_cfg_wr_data;
            end
            if (consume) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_is_last;
        end
    end

endmodule

FILE: rtl/avc_outbuf.sv
// ---------------------------------------------------------------------------
// avc_outbuf: result buffer
// Takes the results of one request at once and shifts them out one per
// accepted output beat; slot 0 is the output register.
// ---------------------------------------------------------------------------
module avc_outbuf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  avc_pkg::t_burst            i_burst,
    output logic                       o_free,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [avc_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_run_last,
    output logic                       o_string_end
);
    import avc_pkg::*;

    logic [RES_CNT_W-1:0]           r_cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] r_data;
    logic [MAX_RES-1:0]             r_ends;
    logic                           pop;

    assign pop          = o_valid && i_ready;
    assign o_valid      = (r_cnt != '0);
    assign o_free       = (r_cnt == '0) || (r_cnt == RES_CNT_W'(1) && pop);
    assign o_out_byte   = r_data[0];
    assign o_string_end = r_ends[0];
    assign o_run_last   = (r_cnt == RES_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_burst.data;
            r_ends <= i_burst.ends;
        end else if (pop) begin
            // advance the queue by one slot
            r_data <= {BYTE_W'(0), r_data[MAX_RES-1:1]};
            r_ends <= {1'b0, r_ends[MAX_RES-1:1]};
        end
    end

endmodule

FILE: rtl/ansi_aware_visible_clip.sv
// ---------------------------------------------------------------------------
// ansi_aware_visible_clip: clip a byte string to a visible column limit
// Escape-aware truncation with pass-through of CSI sequences.
// ---------------------------------------------------------------------------
// One request is one string byte; the block takes a request in every cycle
// while each request yields at most one result and the output does not
// stall. A request that yields more results (a released ESC plus a byte, or
// the four-byte reset sequence on truncation) holds the result buffer until
// its last result is taken, and the input stalls behind it. The first result
// goes through one input register, one pass of decode logic and one result
// register. The column limit must be written only while the block is idle;
// the block does not enforce this. It resets to 79.
module ansi_aware_visible_clip #(
    parameter int COL_BITS = avc_pkg::COL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [avc_pkg::CFG_W-1:0] i_cfg_wr_data,
    avc_in_if.sink                    i_in,
    avc_out_if.source                 o_out
);
    import avc_pkg::*;

    logic   buf_free;
    logic   load;
    t_burst burst;

    avc_core #(
        .COL_BITS (COL_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_in_byte     (i_in.in_byte),
        .i_is_last     (i_in.is_last),
        .i_buf_free    (buf_free),
        .o_load        (load),
        .o_burst       (burst)
    );

    avc_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .o_free       (buf_free),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_out_byte   (o_out.out_byte),
        .o_run_last   (o_out.run_last),
        .o_string_end (o_out.string_end)
    );

endmodule

FILE: rtl/avc_checker.sv
// ---------------------------------------------------------------------------
// avc_checker: port-level checks for the clipper
// Watches the output channel and reset, attached to the top level by bind.
// ---------------------------------------------------------------------------
module avc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [avc_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_run_last,
    input logic                       i_string_end
);
    import avc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_run_last) && $stable(i_string_end))
        else $error("output changed while stalled");

    // reset drains the result buffer
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // the string end is always the final result of its request
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_end |-> i_run_last)
        else $error("string end without run last");

    // a result that is not the last of its request is followed by more
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_run_last |=> i_out_valid)
        else $error("request results broken off");

endmodule

bind ansi_aware_visible_clip avc_checker u_avc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_run_last   (o_out.run_last),
    .i_string_end (o_out.string_end)
);

FILE: tb/ansi_aware_visible_clip_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ansi_aware_visible_clip_test: self-checking bench for the column clipper
// Streams byte strings through the clipper under several column limits and
// flow-control patterns. An internal clip predictor runs on every accepted
// request, and each output byte is matched in order against its prediction.
// ---------------------------------------------------------------------------
module ansi_aware_visible_clip_test;
    import avc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [COL_BITS_DEF-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC_HELD,
        MODE_CSI,
        MODE_DROP
    } t_scan_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              string_end;
    } t_clip_byte;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CFG_W-1:0]   i_cfg_wr_data;

    avc_in_if  in_if ();
    avc_out_if out_if ();

    ansi_aware_visible_clip u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // clip predictor state
    t_scan_mode              clip_mode;
    logic [COL_BITS_DEF-1:0] clip_count;
    logic [CFG_W-1:0]        clip_limit;
    t_clip_byte              step_bytes[$];
    t_clip_byte              clip_expect_q[$];

    int fail_count;
    int items_sent;
    int idle_pct;
    int stall_pct;
    int hold_reqs;
    int hold_done;
    int hold_left;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic void add_byte(logic [BYTE_W-1:0] b, logic str_end);
        step_bytes.insert(step_bytes.size(), t_clip_byte'{b, 1'b0, str_end});
    endfunction

    // A byte that costs a column: pass it, or cut the string here.
    function automatic void count_char(logic [BYTE_W-1:0] b, logic last);
        if (clip_count >= COL_BITS_DEF'(clip_limit) || clip_count == COUNT_MAX) begin
            add_byte(CH_ESC, 1'b0);
            add_byte(CH_BRACKET, 1'b0);
            add_byte(CH_ZERO, 1'b0);
            add_byte(CH_M, 1'b1);
            clip_mode = MODE_DROP;
        end else begin
            clip_count = clip_count + 1'b1;
            add_byte(b, last);
        end
    endfunction

    function automatic void text_byte(logic [BYTE_W-1:0] b, logic last);
        if (b == CH_ESC) begin
            if (last) begin
                count_char(b, 1'b1);
            end else begin
                clip_mode = MODE_ESC_HELD;
            end
        end else if (b[7:6] != UTF8_CONT_TAG) begin
            count_char(b, last);
        end else begin
            add_byte(b, last);
        end
    endfunction

    function automatic void predict_clip(logic [BYTE_W-1:0] b, logic last);
        step_bytes.delete();
        case (clip_mode)
            MODE_DROP: begin
            end
            MODE_CSI: begin
                add_byte(b, last);
                if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) clip_mode = MODE_TEXT;
            end
            MODE_ESC_HELD: begin
                if (b == CH_BRACKET) begin
                    add_byte(CH_ESC, 1'b0);
                    add_byte(CH_BRACKET, last);
                    clip_mode = MODE_CSI;
                end else begin
                    // release the held ESC as a character first
                    clip_mode = MODE_TEXT;
                    count_char(CH_ESC, 1'b0);
                    if (clip_mode == MODE_TEXT) text_byte(b, last);
                end
            end
            default: begin
                text_byte(b, last);
            end
        endcase
        if (last) begin
            clip_mode  = MODE_TEXT;
            clip_count = '0;
        end
        if (step_bytes.size() > 0) step_bytes[$].run_last = 1'b1;
        clip_expect_q = {clip_expect_q, step_bytes};
    endfunction

    // ---------------------------------------------------------------------
    // Output side: ready pattern and result check
    // ---------------------------------------------------------------------
    initial begin : receiver
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_reqs) begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_reqs;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_clip_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (clip_expect_q.size() == 0) begin
                $error("out_byte: expected none, got %h", out_if.out_byte);
                fail_count++;
            end else begin
                want = clip_expect_q.pop_front();
                if (out_if.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
                    fail_count++;
                end
                if (out_if.run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, out_if.run_last);
                    fail_count++;
                end
                if (out_if.string_end !== want.string_end) begin
                    $error("string_end: expected %b, got %b",
                           want.string_end, out_if.string_end);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.is_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        predict_clip(b, last);
        items_sent++;
    endtask

    task automatic send_text(input t_byte_q s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    // Drain, let any result-free requests clear the pipe, then write.
    task automatic write_limit(input int unsigned value);
        in_if.valid <= 1'b0;
        while (clip_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(value);
        clip_limit     = CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed text, CSI and UTF-8, with some raw noise; the cut
    // at a random length leaves partial sequences at the end of a string.
    function automatic t_byte_q random_string(int max_len);
        t_byte_q s;
        int len;
        logic [BYTE_W-1:0] b;
        len = $urandom_range(max_len, 1);
        while (s.size() < len) begin
            case ($urandom_range(11))
                0, 1, 2, 3, 4: s.insert(s.size(), BYTE_W'($urandom_range(8'h7e, 8'h20)));
                5, 6: begin
                    s.insert(s.size(), CH_ESC);
                    s.insert(s.size(), CH_BRACKET);
                    repeat ($urandom_range(3))
                        s.insert(s.size(), BYTE_W'($urandom_range(8'h3f, 8'h30)));
                    s.insert(s.size(), BYTE_W'($urandom_range(CSI_FINAL_HI, CSI_FINAL_LO)));
                end
                7: begin
                    s.insert(s.size(), BYTE_W'($urandom_range(8'hf7, 8'hc0)));
                    repeat ($urandom_range(3, 1))
                        s.insert(s.size(), BYTE_W'($urandom_range(8'hbf, 8'h80)));
                end
                8: begin
                    b = BYTE_W'($urandom_range(255));
                    if (b == CH_BRACKET) b = 8'h5c;
                    s.insert(s.size(), CH_ESC);
                    s.insert(s.size(), b);
                end
                10: s.insert(s.size(), BYTE_W'($urandom_range(8'hbf, 8'h80)));
                default: s.insert(s.size(), BYTE_W'($urandom_range(255)));
            endcase
        end
        s = s[0:len-1];
        return s;
    endfunction

    task automatic run_phase(input int unsigned limit, input int idle, input int stall,
                             input int budget);
        int target;
        write_limit(limit);
        idle_pct  = idle;
        stall_pct = stall;
        target    = items_sent + budget;
        while (items_sent < target) begin
            send_text(random_string(($urandom_range(9) == 0) ? 40 : 16));
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_escapes();
        // reset column limit still in force
        send_text('{8'h00});
        send_text('{CH_ESC});
        send_text('{CH_ESC, CH_BRACKET, 8'h33, 8'h31, CH_M, 8'hff});
        send_text('{CH_ESC, 8'h51});
        send_text('{8'hc3, 8'ha9});
        send_text('{CH_ESC, CH_BRACKET, 8'h31});
    endtask

    task automatic test_truncation();
        write_limit(2);
        send_text('{8'h61, 8'h62, 8'h63, 8'h64});
        // held ESC released at the limit cuts the string, drop the rest
        send_text('{8'h61, 8'h62, CH_ESC, 8'h7a});
        write_limit(0);
        send_text('{8'h71});
        send_text('{8'h80, 8'h71, 8'h72});
    endtask

    task automatic test_free_flow();
        run_phase(6, 0, 0, 80);
    endtask

    task automatic test_sender_gaps();
        run_phase(12, 70, 0, 90);
    endtask

    task automatic test_receiver_stalls();
        run_phase(4095, 0, 70, 90);
    endtask

    task automatic test_mixed_idling();
        run_phase(3, 16, 16, 50);
        run_phase(0, 16, 16, 40);
    endtask

    task automatic test_backpressure();
        write_limit(9);
        idle_pct  = 0;
        stall_pct = 0;
        // long receiver hold while requests keep coming
        hold_reqs++;
        run_phase(9, 0, 0, 60);
    endtask

    initial begin
        fail_count    = 0;
        items_sent    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_reqs     = 0;
        hold_done     = 0;
        hold_left     = 0;
        cycle_count   = 0;
        clip_mode     = MODE_TEXT;
        clip_count    = '0;
        clip_limit    = COLUMN_LIMIT_RST;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= '0;
        in_if.is_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_escapes();
        test_truncation();
        test_free_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();

        in_if.valid <= 1'b0;
        while (clip_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
